// ===== rtl/bbzh_pkg.sv =====
// Shared constants, codes and types for the bitboard store with hash.
// Used by the key generator, the store and the testbench; depends on nothing.
package bbzh_pkg;

   localparam int NUM_KINDS   = 6;
   localparam int NUM_COLORS  = 2;
   localparam int NUM_BOARDS  = NUM_COLORS * NUM_KINDS;
   localparam int BOARD_AW    = $clog2(NUM_BOARDS);
   localparam int SQ_W        = 6;
   localparam int PIECE_KEYS  = NUM_BOARDS * 64;
   localparam int CASTLE_BASE = PIECE_KEYS;
   localparam int EP_BASE     = PIECE_KEYS + 4;
   localparam int SIDE_KEY    = PIECE_KEYS + 12;
   localparam int KEY_COUNT   = PIECE_KEYS + 13;
   localparam int KEY_AW      = $clog2(KEY_COUNT);

   localparam logic [2:0] EMPTY_KIND = 3'd6;

   localparam logic [2:0] OP_CLEAR  = 3'd0;
   localparam logic [2:0] OP_PLACE  = 3'd1;
   localparam logic [2:0] OP_REMOVE = 3'd2;
   localparam logic [2:0] OP_QUERY  = 3'd3;
   localparam logic [2:0] OP_RECOMP = 3'd4;

   localparam logic [63:0] KEY_SEED  = 64'h1234abcd5678ef01;
   localparam logic [63:0] KEY_GAMMA = 64'h9e3779b97f4a7c15;
   localparam logic [63:0] KEY_MIX1  = 64'hbf58476d1ce4e5b9;
   localparam logic [63:0] KEY_MIX2  = 64'h94d049bb133111eb;

   typedef struct packed {
      logic              wr;
      logic [KEY_AW-1:0] addr;
      logic              done;
   } keygen_status_type;

endpackage

// ===== rtl/bbzh_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read.
// Self-contained; no package needed.
module bbzh_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/bbzh_keygen.sv =====
// Splitmix64 key generator that fills the key RAM once after reset.
// Depends on bbzh_pkg; each multiply runs as four 64x16 partial products.
module bbzh_keygen (
   input  logic                       clock,
   input  logic                       reset,
   output bbzh_pkg::keygen_status_type status,
   output logic [63:0]                key
);
   import bbzh_pkg::*;

   localparam logic [1:0] KG_ADD  = 2'd0;
   localparam logic [1:0] KG_MUL  = 2'd1;
   localparam logic [1:0] KG_OUT  = 2'd2;
   localparam logic [1:0] KG_DONE = 2'd3;

   logic [1:0]        state_ff, state_in;
   logic [63:0]       x_ff, x_in;
   logic [63:0]       opnd_ff, opnd_in;
   logic [63:0]       acc_ff, acc_in;
   logic [1:0]        step_ff, step_in;
   logic              second_ff, second_in;
   logic [KEY_AW-1:0] idx_ff, idx_in;

   logic [63:0] xa;
   logic [15:0] slice;
   logic [63:0] prod;
   logic [63:0] acc_sum;

   always_comb begin
      xa      = x_ff + KEY_GAMMA;
      slice   = second_ff ? 16'(KEY_MIX2 >> {step_ff, 4'b0000})
                          : 16'(KEY_MIX1 >> {step_ff, 4'b0000});
      prod    = opnd_ff * 64'(slice);
      acc_sum = acc_ff + (prod << {step_ff, 4'b0000});

      state_in  = state_ff;
      x_in      = x_ff;
      opnd_in   = opnd_ff;
      acc_in    = acc_ff;
      step_in   = step_ff;
      second_in = second_ff;
      idx_in    = idx_ff;

      case (state_ff)
         KG_ADD: begin
            x_in      = xa;
            opnd_in   = xa ^ (xa >> 30);
            acc_in    = '0;
            step_in   = '0;
            second_in = 1'b0;
            state_in  = KG_MUL;
         end
         KG_MUL: begin
            acc_in  = acc_sum;
            step_in = step_ff + 2'd1;
            if (step_ff == 2'd3) begin
               if (!second_ff) begin
                  // second round multiplies the remixed product
                  opnd_in   = acc_sum ^ (acc_sum >> 27);
                  acc_in    = '0;
                  second_in = 1'b1;
               end else begin
                  state_in = KG_OUT;
               end
            end
         end
         KG_OUT: begin
            idx_in = idx_ff + KEY_AW'(1);
            if (idx_ff == KEY_AW'(KEY_COUNT - 1)) begin
               state_in = KG_DONE;
            end else begin
               state_in = KG_ADD;
            end
         end
         default: begin
            state_in = KG_DONE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= KG_ADD;
         x_ff      <= KEY_SEED;
         idx_ff    <= '0;
         step_ff   <= '0;
         second_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         x_ff      <= x_in;
         idx_ff    <= idx_in;
         step_ff   <= step_in;
         second_ff <= second_in;
      end
      opnd_ff <= opnd_in;
      acc_ff  <= acc_in;
   end

   assign key         = acc_ff ^ (acc_ff >> 31);
   assign status.wr   = (state_ff == KG_OUT);
   assign status.addr = idx_ff;
   assign status.done = (state_ff == KG_DONE);

endmodule

// ===== rtl/bitboard_store_with_zobrist_hash.sv =====
// Bitboard store with running Zobrist hash: boards and keys live in RAMs.
// Clear and unknown opcodes respond straight from idle; place/remove read the board
// and key, then write; query scans the boards in order; recompute walks each board's set
// bits, then the castle, en passant and side keys. After reset the key RAM is filled by
// the splitmix generator; busy stays high until then. Boards and hash reset to zero.
// One item at a time: start is taken only while idle; the receiver cannot stall.
module bitboard_store_with_zobrist_hash (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [2:0]  req_opcode,
   input  logic        req_piece_color,
   input  logic [2:0]  req_piece_kind,
   input  logic [5:0]  req_square,
   input  logic [3:0]  req_castle_rights,
   input  logic        req_ep_present,
   input  logic [2:0]  req_ep_file,
   input  logic        req_black_to_move,
   output logic        rsp_strobe,
   output logic [2:0]  rsp_found_kind,
   output logic        rsp_found_color,
   output logic [63:0] rsp_board_hash,
   output logic        rsp_occupancy_error
);
   import bbzh_pkg::*;

   localparam logic [2:0] S_INIT = 3'd0;
   localparam logic [2:0] S_IDLE = 3'd1;
   localparam logic [2:0] S_PR   = 3'd2;
   localparam logic [2:0] S_Q    = 3'd3;
   localparam logic [2:0] S_RB   = 3'd4;
   localparam logic [2:0] S_RS   = 3'd5;
   localparam logic [2:0] S_RX   = 3'd6;
   localparam logic [2:0] S_RF   = 3'd7;

   keygen_status_type kg_status;
   logic [63:0]       kg_key;

   logic [KEY_AW-1:0]   key_rd_addr;
   logic [63:0]         key_rdata;
   logic                brd_wr_en;
   logic [BOARD_AW-1:0] brd_rd_addr;
   logic [63:0]         brd_wdata;
   logic [63:0]         brd_rdata;

   logic [2:0]            state_ff, state_in;
   logic [NUM_BOARDS-1:0] valid_ff, valid_in;
   logic [63:0]           hash_ff, hash_in;
   logic [2:0]            op_ff, op_in;
   logic [BOARD_AW-1:0]   b_ff, b_in;
   logic [SQ_W-1:0]       sq_ff, sq_in;
   logic [3:0]            castle_ff, castle_in;
   logic                  epp_ff, epp_in;
   logic [2:0]            epf_ff, epf_in;
   logic                  btm_ff, btm_in;
   logic [BOARD_AW-1:0]   cnt_ff, cnt_in;
   logic [63:0]           bits_ff, bits_in;
   logic [63:0]           acc_ff, acc_in;
   logic                  pend_ff, pend_in;
   logic [2:0]            ex_ff, ex_in;
   logic                  strobe_ff, strobe_in;
   logic [2:0]            fk_ff, fk_in;
   logic                  fc_ff, fc_in;
   logic                  err_ff, err_in;

   logic                kind_ok;
   logic [BOARD_AW-1:0] req_b;
   logic [63:0]         board_word;
   logic                bit_hit;
   logic [63:0]         acc_next;
   logic [SQ_W-1:0]     low_idx;
   logic                ex_issue;
   logic [KEY_AW-1:0]   ex_addr;

   bbzh_keygen u_keygen (
      .clock  (clock),
      .reset  (reset),
      .status (kg_status),
      .key    (kg_key)
   );

   bbzh_ram #(.WIDTH(64), .DEPTH(KEY_COUNT)) u_key_ram (
      .clock   (clock),
      .wr_en   (kg_status.wr),
      .wr_addr (kg_status.addr),
      .wr_data (kg_key),
      .rd_addr (key_rd_addr),
      .rd_data (key_rdata)
   );

   bbzh_ram #(.WIDTH(64), .DEPTH(NUM_BOARDS)) u_board_ram (
      .clock   (clock),
      .wr_en   (brd_wr_en),
      .wr_addr (b_ff),
      .wr_data (brd_wdata),
      .rd_addr (brd_rd_addr),
      .rd_data (brd_rdata)
   );

   always_comb begin
      kind_ok  = ({1'b0, req_piece_kind} < 4'(NUM_KINDS));
      req_b    = req_piece_color ? BOARD_AW'(NUM_KINDS) + BOARD_AW'(req_piece_kind)
                                 : BOARD_AW'(req_piece_kind);
      // a board never written since clear reads as empty
      board_word = valid_ff[cnt_ff] ? brd_rdata : '0;
      bit_hit    = board_word[sq_ff];
      acc_next   = acc_ff ^ (pend_ff ? key_rdata : 64'd0);

      low_idx = '0;
      for (int i = 63; i >= 0; i--) begin
         if (bits_ff[i]) begin
            low_idx = SQ_W'(i);
         end
      end

      ex_issue = 1'b0;
      ex_addr  = KEY_AW'(SIDE_KEY);
      case (ex_ff)
         3'd0, 3'd1, 3'd2, 3'd3: begin
            ex_issue = castle_ff[ex_ff[1:0]];
            ex_addr  = KEY_AW'(CASTLE_BASE) + KEY_AW'(ex_ff[1:0]);
         end
         3'd4: begin
            ex_issue = epp_ff;
            ex_addr  = KEY_AW'(EP_BASE) + KEY_AW'(epf_ff);
         end
         default: begin
            ex_issue = btm_ff;
            ex_addr  = KEY_AW'(SIDE_KEY);
         end
      endcase
   end

   always_comb begin
      state_in  = state_ff;
      valid_in  = valid_ff;
      hash_in   = hash_ff;
      op_in     = op_ff;
      b_in      = b_ff;
      sq_in     = sq_ff;
      castle_in = castle_ff;
      epp_in    = epp_ff;
      epf_in    = epf_ff;
      btm_in    = btm_ff;
      cnt_in    = cnt_ff;
      bits_in   = bits_ff;
      acc_in    = acc_ff;
      pend_in   = 1'b0;
      ex_in     = ex_ff;
      strobe_in = 1'b0;
      fk_in     = EMPTY_KIND;
      fc_in     = 1'b0;
      err_in    = 1'b0;

      brd_wr_en   = 1'b0;
      brd_wdata   = board_word;
      brd_rd_addr = cnt_ff;
      key_rd_addr = KEY_AW'({cnt_ff, low_idx});

      case (state_ff)
         S_INIT: begin
            if (kg_status.done) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            // query and recompute scan from board zero
            brd_rd_addr = (kind_ok && (req_opcode == OP_PLACE || req_opcode == OP_REMOVE))
                          ? req_b : '0;
            key_rd_addr = KEY_AW'({req_b, req_square});
            if (start) begin
               op_in     = req_opcode;
               b_in      = req_b;
               sq_in     = req_square;
               castle_in = req_castle_rights;
               epp_in    = req_ep_present;
               epf_in    = req_ep_file;
               btm_in    = req_black_to_move;
               case (req_opcode)
                  OP_CLEAR: begin
                     valid_in  = '0;
                     hash_in   = '0;
                     strobe_in = 1'b1;
                  end
                  OP_PLACE, OP_REMOVE: begin
                     if (kind_ok) begin
                        cnt_in   = req_b;
                        state_in = S_PR;
                     end else begin
                        strobe_in = 1'b1;
                     end
                  end
                  OP_QUERY: begin
                     cnt_in   = '0;
                     state_in = S_Q;
                  end
                  OP_RECOMP: begin
                     cnt_in   = '0;
                     acc_in   = '0;
                     ex_in    = '0;
                     state_in = S_RB;
                  end
                  default: begin
                     strobe_in = 1'b1;
                  end
               endcase
            end
         end
         S_PR: begin
            brd_wr_en = 1'b1;
            brd_wdata = board_word;
            brd_wdata[sq_ff] = (op_ff == OP_PLACE);
            valid_in[b_ff]   = 1'b1;
            hash_in   = hash_ff ^ key_rdata;
            err_in    = (op_ff == OP_PLACE) ? bit_hit : !bit_hit;
            strobe_in = 1'b1;
            state_in  = S_IDLE;
         end
         S_Q: begin
            brd_rd_addr = cnt_ff + BOARD_AW'(1);
            cnt_in      = cnt_ff + BOARD_AW'(1);
            if (bit_hit) begin
               fc_in     = (cnt_ff >= BOARD_AW'(NUM_KINDS));
               fk_in     = fc_in ? 3'(cnt_ff - BOARD_AW'(NUM_KINDS)) : 3'(cnt_ff);
               strobe_in = 1'b1;
               state_in  = S_IDLE;
            end else if (cnt_ff == BOARD_AW'(NUM_BOARDS - 1)) begin
               strobe_in = 1'b1;
               state_in  = S_IDLE;
            end
         end
         S_RB: begin
            acc_in   = acc_next;
            bits_in  = board_word;
            state_in = S_RS;
         end
         S_RS: begin
            acc_in = acc_next;
            if (bits_ff != '0) begin
               // fetch the key of the lowest set square, drop that bit
               pend_in = 1'b1;
               bits_in = bits_ff & (bits_ff - 64'd1);
            end else if (cnt_ff == BOARD_AW'(NUM_BOARDS - 1)) begin
               state_in = S_RX;
            end else begin
               brd_rd_addr = cnt_ff + BOARD_AW'(1);
               cnt_in      = cnt_ff + BOARD_AW'(1);
               state_in    = S_RB;
            end
         end
         S_RX: begin
            acc_in      = acc_next;
            key_rd_addr = ex_addr;
            pend_in     = ex_issue;
            ex_in       = ex_ff + 3'd1;
            if (ex_ff == 3'd5) begin
               state_in = S_RF;
            end
         end
         default: begin
            hash_in   = acc_next;
            strobe_in = 1'b1;
            state_in  = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_INIT;
         valid_ff  <= '0;
         hash_ff   <= '0;
         pend_ff   <= 1'b0;
         strobe_ff <= 1'b0;
         cnt_ff    <= '0;
         ex_ff     <= '0;
      end else begin
         state_ff  <= state_in;
         valid_ff  <= valid_in;
         hash_ff   <= hash_in;
         pend_ff   <= pend_in;
         strobe_ff <= strobe_in;
         cnt_ff    <= cnt_in;
         ex_ff     <= ex_in;
      end
      op_ff     <= op_in;
      b_ff      <= b_in;
      sq_ff     <= sq_in;
      castle_ff <= castle_in;
      epp_ff    <= epp_in;
      epf_ff    <= epf_in;
      btm_ff    <= btm_in;
      bits_ff   <= bits_in;
      acc_ff    <= acc_in;
      fk_ff     <= fk_in;
      fc_ff     <= fc_in;
      err_ff    <= err_in;
   end

   assign busy                = (state_ff != S_IDLE);
   assign rsp_strobe          = strobe_ff;
   assign rsp_found_kind      = fk_ff;
   assign rsp_found_color     = fc_ff;
   assign rsp_board_hash      = hash_ff;
   assign rsp_occupancy_error = err_ff;

endmodule

// ===== tb/sv/tb_top.sv =====
// Testbench for the bitboard store with Zobrist hash: drives place, remove,
// query, recompute, clear and unused-opcode commands and checks every result strobe.
// Depends on bbzh_pkg and the bitboard_store_with_zobrist_hash RTL.
`timescale 1ns / 1ps

import bbzh_pkg::*;

class hash_board_scoreboard;
   logic [63:0] zkeys[KEY_COUNT];
   logic [63:0] boards[NUM_BOARDS];
   logic [63:0] cur_hash;
   logic [2:0]  want_kind[$];
   logic        want_color[$];
   logic [63:0] want_hash[$];
   logic        want_err[$];
   int          mismatches;

   function new();
      logic [63:0] x, z;
      x = KEY_SEED;
      for (int i = 0; i < KEY_COUNT; i++) begin
         x = x + KEY_GAMMA;
         z = x;
         z = (z ^ (z >> 30)) * KEY_MIX1;
         z = (z ^ (z >> 27)) * KEY_MIX2;
         zkeys[i] = z ^ (z >> 31);
      end
      foreach (boards[b]) boards[b] = '0;
      cur_hash = '0;
      mismatches = 0;
   endfunction

   // Apply one accepted command and queue the result it should produce.
   function void note_command(logic [2:0] op, logic color, logic [2:0] kind,
                              logic [5:0] sq, logic [3:0] castle, logic ep_on,
                              logic [2:0] ep_f, logic black);
      logic [2:0] fk;
      logic fc, err, hit, was_set;
      int b;
      fk = EMPTY_KIND; fc = 1'b0; err = 1'b0; hit = 1'b0;
      case (op)
         OP_CLEAR: begin
            foreach (boards[i]) boards[i] = '0;
            cur_hash = '0;
         end
         OP_PLACE, OP_REMOVE: begin
            if (kind < NUM_KINDS) begin
               b = color * NUM_KINDS + kind;
               was_set = boards[b][sq];
               err = (op == OP_PLACE) ? was_set : !was_set;
               boards[b][sq] = (op == OP_PLACE);
               cur_hash ^= zkeys[b * 64 + sq];
            end
         end
         OP_QUERY: begin
            for (int c = 0; c < NUM_COLORS; c++)
               for (int k = 0; k < NUM_KINDS; k++)
                  if (!hit && boards[c * NUM_KINDS + k][sq]) begin
                     fk = 3'(k); fc = 1'(c); hit = 1'b1;
                  end
         end
         OP_RECOMP: begin
            cur_hash = '0;
            for (int i = 0; i < NUM_BOARDS; i++)
               for (int s = 0; s < 64; s++)
                  if (boards[i][s]) cur_hash ^= zkeys[i * 64 + s];
            for (int i = 0; i < 4; i++)
               if (castle[i]) cur_hash ^= zkeys[CASTLE_BASE + i];
            if (ep_on) cur_hash ^= zkeys[EP_BASE + ep_f];
            if (black) cur_hash ^= zkeys[SIDE_KEY];
         end
         default: ;
      endcase
      want_kind.push_back(fk);
      want_color.push_back(fc);
      want_hash.push_back(cur_hash);
      want_err.push_back(err);
   endfunction

   function void check_result(logic [2:0] kind, logic color, logic [63:0] hash,
                              logic err);
      logic [2:0] ek;
      logic ec, ee;
      logic [63:0] eh;
      if (want_kind.size() == 0) begin
         mismatches++;
         if (mismatches <= 10) $display("unexpected result strobe at %0t", $time);
         return;
      end
      ek = want_kind.pop_front();
      ec = want_color.pop_front();
      eh = want_hash.pop_front();
      ee = want_err.pop_front();
      if (kind !== ek || color !== ec || hash !== eh || err !== ee) begin
         mismatches++;
         if (mismatches <= 10)
            $display({"result mismatch at %0t: exp kind %0d color %0b hash %h err %0b,",
                      " got kind %0d color %0b hash %h err %0b"},
                     $time, ek, ec, eh, ee, kind, color, hash, err);
      end
   endfunction

   function int pending();
      return want_kind.size();
   endfunction
endclass

module tb_top;
   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [2:0]  req_opcode = '0;
   logic        req_piece_color = 1'b0;
   logic [2:0]  req_piece_kind = '0;
   logic [5:0]  req_square = '0;
   logic [3:0]  req_castle_rights = '0;
   logic        req_ep_present = 1'b0;
   logic [2:0]  req_ep_file = '0;
   logic        req_black_to_move = 1'b0;
   logic        rsp_strobe;
   logic [2:0]  rsp_found_kind;
   logic        rsp_found_color;
   logic [63:0] rsp_board_hash;
   logic        rsp_occupancy_error;

   hash_board_scoreboard board_sb = new();
   int unsigned cycle_count = 0;
   bit          allow_gaps = 1'b1;
   // Squares recently placed, so removes often hit a real piece.
   logic [9:0]  placed[$];

   localparam int unsigned CYCLE_LIMIT = 2_000_000;

   bitboard_store_with_zobrist_hash uut (.*);

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_strobe)
         board_sb.check_result(rsp_found_kind, rsp_found_color, rsp_board_hash,
                               rsp_occupancy_error);
   end

   // Start stays high after an accept; the next call either drives a new item
   // at once or drops start for the idle gap.
   task automatic send_command(logic [2:0] op, logic color, logic [2:0] kind,
                               logic [5:0] sq, logic [3:0] castle, logic ep_on,
                               logic [2:0] ep_f, logic black);
      int gap;
      if (allow_gaps && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 6);
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_opcode <= op;
      req_piece_color <= color;
      req_piece_kind <= kind;
      req_square <= sq;
      req_castle_rights <= castle;
      req_ep_present <= ep_on;
      req_ep_file <= ep_f;
      req_black_to_move <= black;
      do @(posedge clock); while (busy);
      board_sb.note_command(op, color, kind, sq, castle, ep_on, ep_f, black);
   endtask

   task automatic send_random();
      int pick;
      logic [2:0] op, kind;
      logic color;
      logic [5:0] sq;
      logic [9:0] p;
      pick = $urandom_range(0, 99);
      color = 1'($urandom_range(0, 1));
      kind = 3'($urandom_range(0, 5));
      sq = 6'($urandom_range(0, 63));
      if (pick < 1) op = OP_CLEAR;
      else if (pick < 40) op = OP_PLACE;
      else if (pick < 62) op = OP_REMOVE;
      else if (pick < 82) op = OP_QUERY;
      else if (pick < 96) op = OP_RECOMP;
      else op = 3'($urandom_range(5, 7));
      if (op == OP_REMOVE && placed.size() > 0 && $urandom_range(0, 3) != 0) begin
         p = placed[$urandom_range(0, placed.size() - 1)];
         {color, kind, sq} = p;
      end
      if (op == OP_QUERY && placed.size() > 0 && $urandom_range(0, 1) == 0)
         sq = placed[$urandom_range(0, placed.size() - 1)][5:0];
      // Kind out of range should leave the boards alone.
      if ((op == OP_PLACE || op == OP_REMOVE) && $urandom_range(0, 19) == 0)
         kind = 3'($urandom_range(6, 7));
      if (op == OP_PLACE && kind < NUM_KINDS) begin
         placed.push_back({color, kind, sq});
         if (placed.size() > 40) void'(placed.pop_front());
      end
      if (op == OP_CLEAR) placed.delete();
      send_command(op, color, kind, sq, 4'($urandom_range(0, 15)),
                   1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)),
                   1'($urandom_range(0, 1)));
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: each opcode, extremes, flag cases, unused codes.
      send_command(OP_QUERY, 1'b0, 3'd0, 6'd0, 4'd0, 1'b0, 3'd0, 1'b0);
      send_command(OP_PLACE, 1'b0, 3'd0, 6'd0, 4'd0, 1'b0, 3'd0, 1'b0);
      send_command(OP_PLACE, 1'b0, 3'd0, 6'd0, 4'd0, 1'b0, 3'd0, 1'b0);
      send_command(OP_PLACE, 1'b1, 3'd5, 6'd63, 4'd0, 1'b0, 3'd0, 1'b0);
      send_command(OP_PLACE, 1'b1, 3'd2, 6'd0, 4'd0, 1'b0, 3'd0, 1'b0);
      send_command(OP_QUERY, 1'b0, 3'd0, 6'd0, 4'd0, 1'b0, 3'd0, 1'b0);
      send_command(OP_QUERY, 1'b0, 3'd0, 6'd63, 4'd0, 1'b0, 3'd0, 1'b0);
      send_command(OP_PLACE, 1'b1, 3'd7, 6'd21, 4'd0, 1'b0, 3'd0, 1'b0);
      send_command(OP_REMOVE, 1'b0, 3'd6, 6'd0, 4'd0, 1'b0, 3'd0, 1'b0);
      send_command(OP_REMOVE, 1'b0, 3'd3, 6'd42, 4'd0, 1'b0, 3'd0, 1'b0);
      send_command(OP_RECOMP, 1'b0, 3'd0, 6'd0, 4'd15, 1'b1, 3'd7, 1'b1);
      send_command(OP_RECOMP, 1'b0, 3'd0, 6'd0, 4'd0, 1'b0, 3'd5, 1'b0);
      send_command(OP_RECOMP, 1'b0, 3'd0, 6'd0, 4'd5, 1'b1, 3'd0, 1'b0);
      send_command(OP_REMOVE, 1'b0, 3'd0, 6'd0, 4'd0, 1'b0, 3'd0, 1'b0);
      send_command(OP_QUERY, 1'b1, 3'd0, 6'd0, 4'd0, 1'b0, 3'd0, 1'b0);
      send_command(3'd5, 1'b1, 3'd7, 6'd63, 4'd15, 1'b1, 3'd7, 1'b1);
      send_command(3'd6, 1'b0, 3'd0, 6'd0, 4'd0, 1'b0, 3'd0, 1'b0);
      send_command(3'd7, 1'b0, 3'd0, 6'd0, 4'd0, 1'b0, 3'd0, 1'b0);
      send_command(OP_CLEAR, 1'b0, 3'd0, 6'd0, 4'd0, 1'b0, 3'd0, 1'b0);
      send_command(OP_QUERY, 1'b0, 3'd0, 6'd63, 4'd0, 1'b0, 3'd0, 1'b0);

      for (int n = 0; n < 1700; n++) begin
         if (n == 800) begin
            // Drain fully before carrying on.
            start <= 1'b0;
            while (board_sb.pending() != 0) @(posedge clock);
         end
         if (n == 1400) allow_gaps = 1'b0;
         send_random();
      end

      start <= 1'b0;
      while (board_sb.pending() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (board_sb.mismatches == 0 && board_sb.pending() == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end
endmodule
